// ----- design/tbdt_pkg.sv -----
// tbdt_pkg: shared constants, types and control structs for the trained
// branch direction table
// no dependencies
package tbdt_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = IDX_W + 1;
	localparam int ADDR_W = 32;
	localparam int CNT8_W = 8;
	localparam int CTR_W = 32;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// register map, by word index
	localparam logic REG_TRAINING_WINDOW = 1'b0;
	localparam logic [CNT8_W-1:0] WINDOW_RESET = 8'd8;

	// input kinds
	localparam logic KIND_PREDICT = 1'b0;
	localparam logic KIND_RESOLVE = 1'b1;

	typedef enum logic [1:0] {
		MODE_FREE      = 2'd0,
		MODE_TRAIN     = 2'd1,
		MODE_TAKEN     = 2'd2,
		MODE_NOT_TAKEN = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_SCAN   = 2'd1,
		ST_UPDATE = 2'd2
	} state_t;

	// one table entry as held in the entry memory
	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [CNT8_W-1:0] hits;
		logic [CNT8_W-1:0] outcomes;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic scan;
		logic update;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last;
	} sts_t;

endpackage

// ----- design/tbdt_ctrl.sv -----
// tbdt_ctrl: sequencing state machine for the trained branch direction table
// depends on tbdt_pkg
module tbdt_ctrl
	import tbdt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output logic busy,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_next;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_next = ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.scan_last) state_next = ST_UPDATE;
			end
			ST_UPDATE: begin
				state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		busy = 1'b1;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				cmd.load = start;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

// ----- design/tbdt_dp.sv -----
// tbdt_dp: entry memory, mode flags, search datapath, training update and
// global counters
// depends on tbdt_pkg
module tbdt_dp
	import tbdt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic [CNT8_W-1:0] window,
	input  logic              kind,
	input  logic [ADDR_W-1:0] branch_address,
	input  logic              was_correct,
	output logic              done,
	output logic              predict_taken,
	output logic [CTR_W-1:0]  total_resolved,
	output logic [CTR_W-1:0]  total_correct
);

	entry_t entry_mem [TABLE_ENTRIES];
	mode_t  mode_q [TABLE_ENTRIES];

	// latched beat
	logic              kind_q;
	logic [ADDR_W-1:0] addr_q;
	logic              correct_q;

	// scan state
	logic [CNT_W-1:0] ptr_q;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	entry_t           rd_data_s1;
	logic             issue;
	mode_t            cur_mode;
	logic             cur_hit;
	logic             cur_free;

	// search results
	logic              found_q;
	logic [IDX_W-1:0]  hit_idx_q;
	mode_t             hit_mode_q;
	logic [CNT8_W-1:0] hit_hits_q;
	logic [CNT8_W-1:0] hit_outc_q;
	logic              free_found_q;
	logic [IDX_W-1:0]  free_idx_q;

	// update
	logic [CNT8_W-1:0] half;
	logic [CNT8_W-1:0] new_hits;
	logic [CNT8_W-1:0] new_outc;
	logic [CNT8_W-1:0] miss_cnt;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_idx;
	entry_t            wr_data;
	mode_t             wr_mode;
	logic              taken;

	logic              done_q;
	logic              taken_q;
	logic [CTR_W-1:0]  resolved_q;
	logic [CTR_W-1:0]  correct_cnt_q;

	assign issue = cmd.scan && (ptr_q < CNT_W'(TABLE_ENTRIES));
	assign sts.scan_last = (ptr_q == CNT_W'(TABLE_ENTRIES));

	assign cur_mode = mode_q[rd_idx_s1];
	assign cur_hit  = rd_vld_s1 && (cur_mode != MODE_FREE) && (rd_data_s1.addr == addr_q);
	assign cur_free = rd_vld_s1 && (cur_mode == MODE_FREE);

	// beat capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q    <= kind;
			addr_q    <= branch_address;
			correct_q <= was_correct;
		end
	end

	// entry memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_mem[wr_idx] <= wr_data;
		end
		if (issue) begin
			rd_data_s1 <= entry_mem[ptr_q[IDX_W-1:0]];
		end
	end

	// scan pointer and read tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else if (cmd.load) begin
			ptr_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (issue) ptr_q <= ptr_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (issue) rd_idx_s1 <= ptr_q[IDX_W-1:0];
	end

	// first match and first free slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
		end else if (cmd.load) begin
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			if (cur_hit) found_q <= 1'b1;
			if (cur_free) free_found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cur_hit && !found_q) begin
			hit_idx_q  <= rd_idx_s1;
			hit_mode_q <= cur_mode;
			hit_hits_q <= rd_data_s1.hits;
			hit_outc_q <= rd_data_s1.outcomes;
		end
		if (cur_free && !free_found_q) begin
			free_idx_q <= rd_idx_s1;
		end
	end

	// training arithmetic, all 8-bit wrapping
	assign half     = window >> 1;
	assign new_hits = hit_hits_q + CNT8_W'(correct_q);
	assign new_outc = hit_outc_q + CNT8_W'(1);
	assign miss_cnt = new_outc - new_hits;

	// entry update decision
	always_comb begin
		wr_en   = 1'b0;
		wr_idx  = hit_idx_q;
		wr_data = '{addr: addr_q, hits: new_hits, outcomes: hit_outc_q};
		wr_mode = MODE_TRAIN;
		taken   = 1'b0;
		case (kind_q)
			KIND_PREDICT: begin
				taken = !(found_q && (hit_mode_q == MODE_NOT_TAKEN));
				if (!found_q && free_found_q) begin
					wr_en   = cmd.update;
					wr_idx  = free_idx_q;
					wr_data = '{addr: addr_q, hits: '0, outcomes: '0};
					wr_mode = MODE_TRAIN;
				end
			end
			KIND_RESOLVE: begin
				if (found_q && (hit_mode_q == MODE_TRAIN)) begin
					wr_en = cmd.update;
					if (new_hits > half) begin
						wr_mode = MODE_TAKEN;
					end else begin
						wr_data.outcomes = new_outc;
						if ((new_outc >= new_hits) && (miss_cnt > half)) begin
							wr_mode = MODE_NOT_TAKEN;
						end
					end
				end
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// mode flags, cleared to free by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				mode_q[i] <= MODE_FREE;
			end
		end else if (wr_en) begin
			mode_q[wr_idx] <= wr_mode;
		end
	end

	// global counters and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q        <= 1'b0;
			resolved_q    <= '0;
			correct_cnt_q <= '0;
		end else begin
			done_q <= cmd.update;
			if (cmd.update && (kind_q == KIND_RESOLVE)) begin
				resolved_q <= resolved_q + CTR_W'(1);
				if (correct_q) correct_cnt_q <= correct_cnt_q + CTR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) taken_q <= taken;
	end

	assign done           = done_q;
	assign predict_taken  = taken_q;
	assign total_resolved = resolved_q;
	assign total_correct  = correct_cnt_q;

endmodule

// ----- design/trained_branch_direction_table.sv -----
// trained_branch_direction_table: top level, config register, controller and datapath
// start is taken in idle; the search then reads one entry per cycle and compares it, and the
// update state writes the entry and registers the result strobe (done); a new item is taken only
// once the block is back in idle, as busy shows; done never stalls
// reset: async, table modes all free, counters zero, training_window 8
// depends on tbdt_pkg, tbdt_ctrl, tbdt_dp
module trained_branch_direction_table
	import tbdt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               start,
	output logic               busy,
	input  logic               kind,
	input  logic [ADDR_W-1:0]  branch_address,
	input  logic               was_correct,
	output logic               done,
	output logic               predict_taken,
	output logic [CTR_W-1:0]   total_resolved,
	output logic [CTR_W-1:0]   total_correct
);

	logic [CNT8_W-1:0] window_q;
	logic              reg_sel;
	cmd_t              cmd;
	sts_t              sts;

	assign pready  = 1'b1;
	assign reg_sel = paddr[PADDR_W-1];

	// training window register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (psel && penable && pwrite && (reg_sel == REG_TRAINING_WINDOW)) begin
			window_q <= pwdata[CNT8_W-1:0];
		end
	end

	// register readback
	always_comb begin
		prdata = '0;
		if (reg_sel == REG_TRAINING_WINDOW) prdata = PDATA_W'(window_q);
	end

	tbdt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	tbdt_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.window         (window_q),
		.kind           (kind),
		.branch_address (branch_address),
		.was_correct    (was_correct),
		.done           (done),
		.predict_taken  (predict_taken),
		.total_resolved (total_resolved),
		.total_correct  (total_correct)
	);

	// accepted beat always enters the busy window
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted beat did not raise busy");

	// end of work always comes with a result strobe
	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy fell without a result");

	// one strobe per item
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe lasted more than one cycle");

	// resolved counter only moves with a result
	a_ctr_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(total_resolved) |-> done)
		else $error("resolved counter changed outside a result");

endmodule
